[sv/tvns_pkg.sv]
`default_nettype none

package tvns_pkg;

   // table depth per voice and stored duration width
   localparam int NOTE_DEPTH    = 256;
   localparam int DURATION_BITS = 16;

   localparam int NUM_VOICES = 2;
   localparam int IDX_W      = $clog2(NOTE_DEPTH);
   localparam int POS_W      = $clog2(NOTE_DEPTH + 1);
   localparam int TIME_W     = 32;

   localparam int FREQ_W  = 5;
   localparam int CTRL_W  = 4;
   localparam int LEN_W   = 9;
   localparam int GAP_W   = 16;
   localparam int TICKS_W = 16;
   localparam int INDEX_W = 8;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(8);

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_VOICE0_LENGTH = 2'd0,
      CSR_VOICE1_LENGTH = 2'd1,
      CSR_GAP_TICKS     = 2'd2
   } csr_index_type;

   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_TICK = 1'b1
   } kind_type;

   typedef struct packed {
      logic [FREQ_W-1:0]        freq;
      logic [CTRL_W-1:0]        ctrl;
      logic [DURATION_BITS-1:0] dur;
   } entry_type;

   // result beat, freq0 in the lowest bits
   typedef struct packed {
      logic              done1;
      logic              done0;
      logic [CTRL_W-1:0] ctrl1;
      logic [FREQ_W-1:0] freq1;
      logic [CTRL_W-1:0] ctrl0;
      logic [FREQ_W-1:0] freq0;
   } rsp_type;

endpackage

`default_nettype wire

[sv/two_voice_note_sequencer_top.sv]
`default_nettype none
// the result beat of an item is registered into the output buffer when the item is accepted
// throughput: one item (load or tick) per cycle unless req stalls; each voice's note memory is read every cycle
//   at the position the voice will hold next, so the read data is ready for the next tick
// a two-beat output buffer lets req keep flowing while a result waits on rsp
// reset: synchronous, clears tick counter, voice state, buffer and registers (gap to 8);
//   the note memories are not cleared and hold nothing defined until loaded
module two_voice_note_sequencer_top (
   input  wire                               clock,
   input  wire                               reset,
   // req_tdata: voice, entry_index, entry_freq, entry_ctrl, entry_ticks, zero fill
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [tvns_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // req_tuser: kind
   input  wire                               req_tuser,
   // rsp_tdata: freq0, ctrl0, freq1, ctrl1, done0, done1, zero fill
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [tvns_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  wire                               csr_we,
   input  wire  [tvns_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire  [tvns_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tvns_pkg::*;

   // ---------------------------------------------------------------
   // request decode
   // ---------------------------------------------------------------
   logic                 req_fire;
   logic                 load_fire;
   logic                 tick_fire;
   logic                 req_voice;
   logic [INDEX_W-1:0]   req_index;
   logic [FREQ_W-1:0]    req_freq;
   logic [CTRL_W-1:0]    req_ctrl;
   logic [TICKS_W-1:0]   req_ticks;
   entry_type            wr_entry;
   logic [IDX_W-1:0]     wr_addr;

   assign req_fire  = req_tvalid && req_tready;
   assign load_fire = req_fire && (kind_type'(req_tuser) == KIND_LOAD);
   assign tick_fire = req_fire && (kind_type'(req_tuser) == KIND_TICK);

   assign req_voice = req_tdata[0];
   assign req_index = req_tdata[8:1];
   assign req_freq  = req_tdata[13:9];
   assign req_ctrl  = req_tdata[17:14];
   assign req_ticks = req_tdata[33:18];

   assign wr_entry.freq = req_freq;
   assign wr_entry.ctrl = req_ctrl;
   assign wr_entry.dur  = DURATION_BITS'(req_ticks);
   assign wr_addr       = IDX_W'(req_index);

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [LEN_W-1:0] len0_ff;
   logic [LEN_W-1:0] len1_ff;
   logic [GAP_W-1:0] gap_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len0_ff      <= '0;
         len1_ff      <= '0;
         gap_ticks_ff <= GAP_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_VOICE0_LENGTH: len0_ff      <= csr_wdata[LEN_W-1:0];
            CSR_VOICE1_LENGTH: len1_ff      <= csr_wdata[LEN_W-1:0];
            CSR_GAP_TICKS:     gap_ticks_ff <= csr_wdata[GAP_W-1:0];
            default: ;  // writes past the register list are dropped
         endcase
      end
   end

   // lengths above the table depth act as the full table
   logic [POS_W-1:0] len_eff [NUM_VOICES];

   always_comb begin
      len_eff[0] = (32'(len0_ff) > 32'(NOTE_DEPTH)) ? POS_W'(NOTE_DEPTH) : POS_W'(len0_ff);
      len_eff[1] = (32'(len1_ff) > 32'(NOTE_DEPTH)) ? POS_W'(NOTE_DEPTH) : POS_W'(len1_ff);
   end

   // ---------------------------------------------------------------
   // voice state
   // ---------------------------------------------------------------
   logic [TIME_W-1:0] tick_ff;
   logic [TIME_W-1:0] tick_in;
   logic [TIME_W-1:0] net_ff  [NUM_VOICES];
   logic [TIME_W-1:0] net_in  [NUM_VOICES];
   logic [POS_W-1:0]  pos_ff  [NUM_VOICES];
   logic [POS_W-1:0]  pos_in  [NUM_VOICES];
   logic              gap_ff  [NUM_VOICES];
   logic              gap_in  [NUM_VOICES];
   logic              fin_ff  [NUM_VOICES];
   logic              fin_in  [NUM_VOICES];
   logic [FREQ_W-1:0] freq_ff [NUM_VOICES];
   logic [FREQ_W-1:0] freq_in [NUM_VOICES];
   logic [CTRL_W-1:0] ctrl_ff [NUM_VOICES];
   logic [CTRL_W-1:0] ctrl_in [NUM_VOICES];

   // registered memory read data: entry at the current position and the one after it
   entry_type cur_rd [NUM_VOICES];
   entry_type nxt_rd [NUM_VOICES];

   // ---------------------------------------------------------------
   // note memories, one per voice, one write and two reads a cycle
   // the read address is the position the voice takes at this edge, so
   // the read data always belongs to pos_ff; a load into an address being
   // read is forwarded into the read register
   // ---------------------------------------------------------------
   for (genvar v = 0; v < NUM_VOICES; v++) begin : g_voice_mem
      entry_type        mem [NOTE_DEPTH];
      entry_type        cur_rd_ff;
      entry_type        nxt_rd_ff;
      logic [POS_W-1:0] rd_pos;
      logic [POS_W-1:0] rd_pos_next;
      logic [IDX_W-1:0] cur_addr;
      logic [IDX_W-1:0] nxt_addr;
      logic             wr_en;

      assign rd_pos      = reset ? '0 : pos_in[v];
      assign rd_pos_next = rd_pos + POS_W'(1);
      assign cur_addr    = rd_pos[IDX_W-1:0];
      assign nxt_addr    = rd_pos_next[IDX_W-1:0];
      assign wr_en       = load_fire && (req_voice == 1'(v));

      always_ff @(posedge clock) begin
         if (wr_en) begin
            mem[wr_addr] <= wr_entry;
         end
      end

      always_ff @(posedge clock) begin
         cur_rd_ff <= (wr_en && (wr_addr == cur_addr)) ? wr_entry : mem[cur_addr];
         nxt_rd_ff <= (wr_en && (wr_addr == nxt_addr)) ? wr_entry : mem[nxt_addr];
      end

      assign cur_rd[v] = cur_rd_ff;
      assign nxt_rd[v] = nxt_rd_ff;
   end

   // ---------------------------------------------------------------
   // event logic: a voice acts on a tick whose count equals its event time
   // ---------------------------------------------------------------
   always_comb begin
      logic [POS_W:0]    pos_plus;
      logic [TIME_W-1:0] dur_w;
      logic [TIME_W-1:0] gap_w;
      logic [TIME_W-1:0] step;
      logic              repeat_note;

      tick_in = tick_fire ? tick_ff + TIME_W'(1) : tick_ff;
      gap_w   = TIME_W'(gap_ticks_ff);

      for (int v = 0; v < NUM_VOICES; v++) begin
         net_in[v]  = net_ff[v];
         pos_in[v]  = pos_ff[v];
         gap_in[v]  = gap_ff[v];
         fin_in[v]  = fin_ff[v];
         freq_in[v] = freq_ff[v];
         ctrl_in[v] = ctrl_ff[v];

         pos_plus    = {1'b0, pos_ff[v]} + (POS_W+1)'(1);
         dur_w       = TIME_W'(cur_rd[v].dur);
         repeat_note = (pos_plus < {1'b0, len_eff[v]}) &&
                       (nxt_rd[v].freq == cur_rd[v].freq) &&
                       (nxt_rd[v].ctrl == cur_rd[v].ctrl) &&
                       (dur_w > gap_w);
         step        = '0;

         if (tick_fire && (tick_ff == net_ff[v])) begin
            if (pos_ff[v] >= len_eff[v]) begin
               // past the last note: silence and flag done, again at each match
               fin_in[v]  = 1'b1;
               ctrl_in[v] = '0;
            end else if (gap_ff[v]) begin
               // silent gap before a repeat of the same note
               ctrl_in[v] = '0;
               gap_in[v]  = 1'b0;
               step       = gap_w;
               pos_in[v]  = pos_plus[POS_W-1:0];
            end else begin
               freq_in[v] = cur_rd[v].freq;
               ctrl_in[v] = cur_rd[v].ctrl;
               if (repeat_note) begin
                  // cut the note short to leave room for the gap
                  step      = dur_w - gap_w;
                  gap_in[v] = 1'b1;
               end else begin
                  step      = dur_w;
                  pos_in[v] = pos_plus[POS_W-1:0];
               end
            end
            net_in[v] = net_ff[v] + step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
         for (int v = 0; v < NUM_VOICES; v++) begin
            net_ff[v]  <= '0;
            pos_ff[v]  <= '0;
            gap_ff[v]  <= 1'b0;
            fin_ff[v]  <= 1'b0;
            freq_ff[v] <= '0;
            ctrl_ff[v] <= '0;
         end
      end else begin
         tick_ff <= tick_in;
         for (int v = 0; v < NUM_VOICES; v++) begin
            net_ff[v]  <= net_in[v];
            pos_ff[v]  <= pos_in[v];
            gap_ff[v]  <= gap_in[v];
            fin_ff[v]  <= fin_in[v];
            freq_ff[v] <= freq_in[v];
            ctrl_ff[v] <= ctrl_in[v];
         end
      end
   end

   // ---------------------------------------------------------------
   // result buffer: head beat on rsp plus one skid beat
   // req is held off in reset and otherwise only while the skid beat is occupied
   // ---------------------------------------------------------------
   rsp_type new_rsp;
   rsp_type head_ff;
   rsp_type head_in;
   rsp_type skid_ff;
   rsp_type skid_in;
   logic    head_valid_ff;
   logic    head_valid_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;
   logic    pop;

   assign new_rsp.freq0 = freq_in[0];
   assign new_rsp.ctrl0 = ctrl_in[0];
   assign new_rsp.freq1 = freq_in[1];
   assign new_rsp.ctrl1 = ctrl_in[1];
   assign new_rsp.done0 = fin_in[0];
   assign new_rsp.done1 = fin_in[1];

   assign pop = head_valid_ff && rsp_tready;

   always_comb begin
      head_in       = head_ff;
      skid_in       = skid_ff;
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            head_valid_in = 1'b1;
            skid_in       = new_rsp;
            skid_valid_in = req_fire;
         end else begin
            head_in       = new_rsp;
            head_valid_in = req_fire;
         end
      end else if (req_fire) begin
         if (!head_valid_ff) begin
            head_in       = new_rsp;
            head_valid_in = 1'b1;
         end else begin
            skid_in       = new_rsp;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign req_tready = !skid_valid_ff && !reset;
   assign rsp_tvalid = head_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(head_ff);

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   // done is sticky once out of reset
   a_done_sticky : assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> !$fell(fin_ff[0]) && !$fell(fin_ff[1]))
      else $error("done flag dropped without reset");

   // the tick counter only moves on an accepted tick
   a_tick_only : assert property (@(posedge clock) disable iff (reset)
      !tick_fire |=> $stable(tick_ff))
      else $error("tick counter moved without a tick");

   // a load into the current position of voice zero is visible next cycle
   a_fwd_cur0 : assert property (@(posedge clock) disable iff (reset)
      load_fire && (req_voice == 1'b0) && (wr_addr == pos_ff[0][IDX_W-1:0])
      |=> cur_rd[0] == $past(wr_entry))
      else $error("load not forwarded to current entry read");

   // the skid beat moves up in order when the head is taken
   a_skid_order : assert property (@(posedge clock) disable iff (reset)
      pop && skid_valid_ff |=> rsp_tvalid && (head_ff == $past(skid_ff)))
      else $error("skid beat lost or reordered");

   // voice state holds while no tick is taken
   a_pos_hold : assert property (@(posedge clock) disable iff (reset)
      !tick_fire |=> $stable(pos_ff[0]) && $stable(pos_ff[1]))
      else $error("note position moved without a tick");

endmodule

`default_nettype wire

[tb/tb.sv]
`default_nettype none

module tb;
   import tvns_pkg::*;

   // one req beat as it sits in req_tdata, voice in the lowest bit
   typedef struct packed {
      logic [REQ_TDATA_W-INDEX_W-FREQ_W-CTRL_W-TICKS_W-2:0] pad;
      logic [TICKS_W-1:0] ticks;
      logic [CTRL_W-1:0]  ctrl;
      logic [FREQ_W-1:0]  freq;
      logic [INDEX_W-1:0] index;
      logic               voice;
   } load_beat_type;

   // tracks both voices and queues the register snapshot each beat should return
   class voice_scoreboard;
      bit [FREQ_W-1:0]        note_freq [NUM_VOICES][NOTE_DEPTH];
      bit [CTRL_W-1:0]        note_ctrl [NUM_VOICES][NOTE_DEPTH];
      bit [DURATION_BITS-1:0] note_dur  [NUM_VOICES][NOTE_DEPTH];
      bit [TIME_W-1:0]        now_tick;
      bit [TIME_W-1:0]        due_tick [NUM_VOICES];
      int unsigned            cursor   [NUM_VOICES];
      bit                     in_gap   [NUM_VOICES];
      bit                     ended    [NUM_VOICES];
      bit [FREQ_W-1:0]        out_freq [NUM_VOICES];
      bit [CTRL_W-1:0]        out_ctrl [NUM_VOICES];
      bit [LEN_W-1:0]         len_cfg  [NUM_VOICES];
      bit [GAP_W-1:0]         gap_cfg;
      rsp_type                expected_regs [$];
      int                     mismatches;

      function new();
         gap_cfg = GAP_RESET;
      endfunction

      function void set_reg(csr_index_type idx, int unsigned value);
         case (idx)
            CSR_VOICE0_LENGTH: len_cfg[0] = value[LEN_W-1:0];
            CSR_VOICE1_LENGTH: len_cfg[1] = value[LEN_W-1:0];
            CSR_GAP_TICKS:     gap_cfg    = value[GAP_W-1:0];
            default: ;
         endcase
      endfunction

      function void play_voice(int v);
         int unsigned lim;
         int unsigned p;
         lim = (len_cfg[v] > NOTE_DEPTH) ? NOTE_DEPTH : len_cfg[v];
         p   = cursor[v];
         if (now_tick != due_tick[v]) return;
         if (p >= lim) begin
            ended[v]    = 1'b1;
            out_ctrl[v] = '0;
            return;
         end
         if (in_gap[v]) begin
            out_ctrl[v]  = '0;
            in_gap[v]    = 1'b0;
            due_tick[v] += gap_cfg;
            cursor[v]    = p + 1;
            return;
         end
         out_freq[v] = note_freq[v][p];
         out_ctrl[v] = note_ctrl[v][p];
         if (p + 1 < lim && note_freq[v][p+1] == note_freq[v][p] &&
             note_ctrl[v][p+1] == note_ctrl[v][p] && note_dur[v][p] > gap_cfg) begin
            due_tick[v] += note_dur[v][p] - gap_cfg;
            in_gap[v]    = 1'b1;
         end else begin
            due_tick[v] += note_dur[v][p];
            cursor[v]    = p + 1;
         end
      endfunction

      function void take_item(kind_type kind, load_beat_type beat);
         rsp_type snap;
         int      slot;
         slot = beat.index % NOTE_DEPTH;
         if (kind == KIND_LOAD) begin
            note_freq[beat.voice][slot] = beat.freq;
            note_ctrl[beat.voice][slot] = beat.ctrl;
            note_dur[beat.voice][slot]  = beat.ticks;
         end else begin
            play_voice(0);
            play_voice(1);
            now_tick++;
         end
         snap.freq0 = out_freq[0];
         snap.ctrl0 = out_ctrl[0];
         snap.freq1 = out_freq[1];
         snap.ctrl1 = out_ctrl[1];
         snap.done0 = ended[0];
         snap.done1 = ended[1];
         expected_regs.push_back(snap);
      endfunction

      function void check_snapshot(logic [RSP_TDATA_W-1:0] beat);
         rsp_type got;
         rsp_type want;
         got = beat[$bits(rsp_type)-1:0];
         if (expected_regs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected rsp beat %h with nothing outstanding", beat);
            return;
         end
         want = expected_regs.pop_front();
         if (got.freq0 !== want.freq0 || got.ctrl0 !== want.ctrl0 ||
             got.freq1 !== want.freq1 || got.ctrl1 !== want.ctrl1 ||
             got.done0 !== want.done0 || got.done1 !== want.done1) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"rsp mismatch: expected f0=%0d c0=%0d f1=%0d c1=%0d d0=%b d1=%b,",
                         " got f0=%0d c0=%0d f1=%0d c1=%0d d0=%b d1=%b"},
                        want.freq0, want.ctrl0, want.freq1, want.ctrl1,
                        want.done0, want.done1,
                        got.freq0, got.ctrl0, got.freq1, got.ctrl1,
                        got.done0, got.done1);
         end
      endfunction
   endclass

   localparam int CYCLE_LIMIT = 100000;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we;
   logic [CSR_ADDR_W-1:0]  csr_addr;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   voice_scoreboard sb = new();

   // random idling on both sides, switched off for one long stretch
   bit idle_on = 1'b1;
   // receiver hold-off: requested by the stimulus, counted down by the receiver
   bit hold_req;
   int hold_left;
   int cycle_count;

   two_voice_note_sequencer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver: checks each accepted rsp beat, then picks next cycle's tready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
         sb.check_snapshot(rsp_tdata);
      if (hold_req) begin
         hold_left = 250;
         hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(idle_on && $urandom_range(99) < 22);
      end
   end

   // random beat with pad kept at zero; ticks carry this as ignored payload
   function automatic load_beat_type junk_beat();
      load_beat_type b;
      b       = '0;
      b.voice = 1'($urandom_range(1));
      b.index = INDEX_W'($urandom_range(NOTE_DEPTH - 1));
      b.freq  = FREQ_W'($urandom_range(31));
      b.ctrl  = CTRL_W'($urandom_range(15));
      b.ticks = TICKS_W'($urandom_range(65535));
      return b;
   endfunction

   // note that may still be played: short nonzero duration, often a repeat of its neighbour
   function automatic load_beat_type fresh_beat(bit v, int idx);
      load_beat_type b;
      b       = '0;
      b.voice = v;
      b.index = INDEX_W'(idx);
      if (idx > 0 && $urandom_range(99) < 40) begin
         b.freq = sb.note_freq[v][idx-1];
         b.ctrl = sb.note_ctrl[v][idx-1];
      end else begin
         b.freq = FREQ_W'($urandom_range(1) ? $urandom_range(3) : $urandom_range(31));
         b.ctrl = CTRL_W'($urandom_range(1) ? $urandom_range(2) : $urandom_range(15));
      end
      b.ticks = TICKS_W'($urandom_range(8, 1));
      return b;
   endfunction

   // offer one beat on req, with random idle cycles ahead of it
   task automatic send_item(input kind_type kind, input load_beat_type beat);
      while (idle_on && $urandom_range(99) < 22) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= beat;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      sb.take_item(kind, beat);
   endtask

   task automatic load_note(input bit v, input int idx, input int f, input int c, input int d);
      load_beat_type b;
      b       = '0;
      b.voice = v;
      b.index = INDEX_W'(idx);
      b.freq  = FREQ_W'(f);
      b.ctrl  = CTRL_W'(c);
      b.ticks = TICKS_W'(d);
      send_item(KIND_LOAD, b);
   endtask

   // mostly ticks; loads land ahead of a voice with playable notes,
   // or behind it (never read again) with any content at all
   task automatic random_item();
      bit v;
      int lo;
      int idx;
      load_beat_type b;
      if ($urandom_range(99) < 78) begin
         send_item(KIND_TICK, junk_beat());
      end else begin
         v  = 1'($urandom_range(1));
         lo = sb.cursor[v];
         if (lo < NOTE_DEPTH && (lo == 0 || $urandom_range(1))) begin
            idx = ($urandom_range(2) == 0) ? lo + $urandom_range(1)
                                           : $urandom_range(NOTE_DEPTH - 1, lo);
            if (idx > NOTE_DEPTH - 1) idx = NOTE_DEPTH - 1;
            b = fresh_beat(v, idx);
         end else begin
            b       = junk_beat();
            b.voice = v;
            b.index = INDEX_W'($urandom_range(lo - 1));
         end
         send_item(KIND_LOAD, b);
      end
   endtask

   // sender stops and waits for every outstanding result
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.expected_regs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input int unsigned value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_reg(idx, value);
      @(posedge clock);
   endtask

   initial begin
      int t;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = KIND_LOAD;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = CSR_VOICE0_LENGTH;
      csr_wdata  = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // short gap, voice zero's length beyond the table depth
      write_reg(CSR_GAP_TICKS, 2);
      write_reg(CSR_VOICE0_LENGTH, 511);
      write_reg(CSR_VOICE1_LENGTH, 256);

      // fill both tables so that no unwritten entry can ever be read
      for (int v = 0; v < NUM_VOICES; v++)
         for (int i = 0; i < NOTE_DEPTH; i++)
            send_item(KIND_LOAD, fresh_beat(1'(v), i));

      // directed: repeats no longer than the gap play in full, a longer one is cut for a gap
      load_note(1'b0, 0, 31, 15, 1);
      load_note(1'b0, 1, 31, 15, 2);
      load_note(1'b0, 2, 31, 15, 5);
      load_note(1'b0, 3, 31, 15, 3);
      load_note(1'b0, 4, 0, 0, 1);
      // silent note first, then a repeated pair, then the top index
      load_note(1'b1, 0, 0, 0, 1);
      load_note(1'b1, 1, 1, 1, 3);
      load_note(1'b1, 2, 1, 1, 4);
      load_note(1'b1, 255, 31, 15, 1);
      repeat (12) send_item(KIND_TICK, junk_beat());
      // both voices are past entry zero by now: extremes of the load fields
      load_note(1'b0, 0, 31, 15, 65535);
      load_note(1'b1, 0, 0, 0, 0);
      // rewrite the note about to be read while playing
      t = sb.cursor[0];
      send_item(KIND_LOAD, fresh_beat(1'b0, (t > NOTE_DEPTH - 1) ? NOTE_DEPTH - 1 : t));
      repeat (2) send_item(KIND_TICK, junk_beat());

      // random, with a long receiver hold-off partway through
      for (int i = 0; i < 250; i++) begin
         if (i == 100) hold_req = 1'b1;
         random_item();
      end
      settle();

      // widest gap: no repeat can be long enough to get one; no idling at all
      write_reg(CSR_GAP_TICKS, 65535);
      write_reg(CSR_VOICE1_LENGTH, 511);
      idle_on = 1'b0;
      for (int i = 0; i < 150; i++) random_item();
      settle();
      idle_on = 1'b1;

      // length change during play
      write_reg(CSR_GAP_TICKS, 3);
      write_reg(CSR_VOICE0_LENGTH, 256);
      write_reg(CSR_VOICE1_LENGTH, 230);
      for (int i = 0; i < 200; i++) random_item();
      settle();

      // zero length ends voice zero at its next event, zero gap, zero duration on voice one
      write_reg(CSR_VOICE0_LENGTH, 0);
      write_reg(CSR_GAP_TICKS, 0);
      t = sb.cursor[1] + sb.in_gap[1];
      if (t < NOTE_DEPTH) load_note(1'b1, t, 2, 3, 0);
      for (int i = 0; i < 60; i++) random_item();

      settle();
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_regs.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
